// File: hw/rtl/lane_height_profile_binner_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lane height profile binner
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LANE_HEIGHT_PROFILE_BINNER_ASSERT_SVH
`define LANE_HEIGHT_PROFILE_BINNER_ASSERT_SVH

// Condition and consequence in the same cycle.
`define LHPB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define LHPB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lhpb_pkg.sv
// ----------------------------------------------------------------------------
// lhpb_pkg
// Types, codes and constants shared by the height profile binner modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lhpb_pkg;

    localparam int DEF_BIN_COUNT = 100;
    localparam int DEF_BIN_MM    = 50;

    localparam int BIN_IDX_W   = 10;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_LANE_CENTER  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_WIDTH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PREVIEW      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_LIMIT = 2'd3;

    localparam logic signed [11:0] RST_LANE_CENTER  = -12'sd300;
    localparam logic [9:0]         RST_HALF_WIDTH   = 10'd100;
    localparam logic [14:0]        RST_PREVIEW      = 15'd5000;
    localparam logic [10:0]        RST_HEIGHT_LIMIT = 11'd500;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic               func;
        logic signed [15:0] x_mm;
        logic signed [15:0] y_mm;
        logic signed [15:0] z_mm;
        logic [6:0]         bin_select;
    } in_item_t;

    typedef struct packed {
        logic [6:0]         bin_index;
        logic signed [11:0] mean_height_mm;
        logic [15:0]        point_count;
    } out_item_t;

    typedef struct packed {
        logic signed [11:0] lane_center_mm;
        logic [9:0]         lane_half_width_mm;
        logic [14:0]        preview_limit_mm;
        logic [10:0]        height_limit_mm;
    } cfg_t;

    typedef struct packed {
        logic                 is_read;
        logic                 hit;
        logic [BIN_IDX_W-1:0] bin;
        logic signed [15:0]   z_mm;
    } op_t;

endpackage

`default_nettype wire

// File: hw/rtl/lhpb_front.sv
// ----------------------------------------------------------------------------
// lhpb_front
// Accepts items, applies the lateral, forward and height window and works
// out the bin of each kept point; pushes kept adds and all reads into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhpb_front #(
    parameter int BIN_COUNT = lhpb_pkg::DEF_BIN_COUNT,
    parameter int BIN_MM    = lhpb_pkg::DEF_BIN_MM
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lhpb_pkg::cfg_t   cfg,
    input  wire logic             clearing,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire lhpb_pkg::in_item_t in_data,
    output logic                  push,
    output lhpb_pkg::op_t         push_op,
    input  wire logic             queue_full
);

    // Division by the bin width as a multiply by a rounded-up reciprocal,
    // exact for every 15 bit forward distance.
    localparam int          BIN_SH    = 15 + $clog2(BIN_MM);
    localparam logic [16:0] BIN_RECIP = 17'(((64'd1 << BIN_SH) + BIN_MM - 1) / BIN_MM);

    logic               s1_valid_reg;
    logic               s1_func_reg;
    logic               s1_keep_reg;
    logic [31:0]        s1_prod_reg;
    logic signed [15:0] s1_z_reg;
    logic [6:0]         s1_sel_reg;

    logic signed [13:0] win_lo;
    logic signed [13:0] win_hi;
    logic               y_ok;
    logic               x_ok;
    logic               z_ok;
    logic [16:0]        z_ext;
    logic [16:0]        z_abs;
    logic [14:0]        bin_q;
    logic               bin_ok;
    logic               sel_ok;
    logic               s1_free;
    logic               accept;

    always_comb
    begin
        win_lo = 14'(cfg.lane_center_mm) - $signed({4'b0, cfg.lane_half_width_mm});
        win_hi = 14'(cfg.lane_center_mm) + $signed({4'b0, cfg.lane_half_width_mm});
        y_ok   = ($signed(in_data.y_mm) >= 16'(win_lo)) &&
                 ($signed(in_data.y_mm) <= 16'(win_hi));
        x_ok   = !in_data.x_mm[15] && (in_data.x_mm[14:0] <= cfg.preview_limit_mm);
        z_ext  = {in_data.z_mm[15], in_data.z_mm};
        z_abs  = in_data.z_mm[15] ? (~z_ext + 17'd1) : z_ext;
        z_ok   = z_abs <= {6'b0, cfg.height_limit_mm};
    end

    always_comb
    begin
        bin_q   = 15'(s1_prod_reg >> BIN_SH);
        bin_ok  = 32'(bin_q) < BIN_COUNT;
        sel_ok  = 32'(s1_sel_reg) < BIN_COUNT;
        push    = s1_valid_reg && ((s1_func_reg == lhpb_pkg::FUNC_READ) ||
                                   (s1_keep_reg && bin_ok)) && !queue_full;
        s1_free = !s1_valid_reg || push ||
                  ((s1_func_reg == lhpb_pkg::FUNC_ADD) && !(s1_keep_reg && bin_ok));
        in_stall = clearing || !s1_free;
        accept   = in_valid && !in_stall;

        push_op.is_read = s1_func_reg;
        push_op.hit     = (s1_func_reg == lhpb_pkg::FUNC_READ) ? sel_ok : 1'b1;
        push_op.bin     = (s1_func_reg == lhpb_pkg::FUNC_READ) ?
                          lhpb_pkg::BIN_IDX_W'(s1_sel_reg) :
                          lhpb_pkg::BIN_IDX_W'(bin_q);
        push_op.z_mm    = s1_z_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= in_data.func;
            s1_keep_reg <= y_ok && x_ok && z_ok;
            s1_prod_reg <= 32'(in_data.x_mm[14:0]) * 32'(BIN_RECIP);
            s1_z_reg    <= in_data.z_mm;
            s1_sel_reg  <= in_data.bin_select;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lhpb_queue.sv
// ----------------------------------------------------------------------------
// lhpb_queue
// Four entry queue of classified operations between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhpb_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire lhpb_pkg::op_t push_op,
    input  wire logic          pop,
    output lhpb_pkg::op_t      head,
    output logic               full,
    output logic               empty
);

    lhpb_pkg::op_t entry_reg [4];
    logic [1:0]    wr_ptr_reg;
    logic [1:0]    rd_ptr_reg;
    logic [2:0]    fill_reg;
    logic [2:0]    fill_next;

    always_comb
    begin
        full      = fill_reg == 3'd4;
        empty     = fill_reg == 3'd0;
        head      = entry_reg[rd_ptr_reg];
        fill_next = fill_reg + 3'(push) - 3'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lhpb_div.sv
// ----------------------------------------------------------------------------
// lhpb_div
// Restoring divider, one quotient bit a cycle: 32 bit magnitude by 16 bit
// count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhpb_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  step_reg;
    logic [15:0] rem_reg;
    logic [31:0] quo_reg;
    logic [15:0] den_reg;

    logic [16:0] trial;
    logic        ge;
    logic [15:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[31]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
        done     = done_reg;
        quotient = quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 5'd1;
            if (step_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lhpb_back.sv
// ----------------------------------------------------------------------------
// lhpb_back
// Holds the per-bin height sums and counts, carries out adds and reads from
// the queue and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lhpb_back #(
    parameter int BIN_COUNT = lhpb_pkg::DEF_BIN_COUNT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    output logic               clearing,
    input  wire lhpb_pkg::op_t head,
    input  wire logic          empty,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output lhpb_pkg::out_item_t out_data
);

    localparam int BIN_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_LOOK  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;

    logic signed [31:0] sum_mem_reg [BIN_COUNT];
    logic [15:0]        cnt_mem_reg [BIN_COUNT];
    logic signed [31:0] sum_rd_reg;
    logic [15:0]        cnt_rd_reg;

    logic [BIN_W-1:0]   clr_cnt_reg;
    lhpb_pkg::op_t      op_reg;
    logic [BIN_W-1:0]   addr_reg;
    logic               neg_reg;
    lhpb_pkg::out_item_t res_reg;
    logic               out_valid_reg;
    lhpb_pkg::out_item_t out_data_reg;

    logic               mem_we;
    logic [BIN_W-1:0]   wr_addr;
    logic [BIN_W-1:0]   rd_addr;
    logic signed [31:0] wr_sum;
    logic [15:0]        wr_cnt;
    logic [15:0]        look_cnt;
    logic               div_start;
    logic               div_done;
    logic [31:0]        div_quo;
    logic [31:0]        div_mag;
    logic [31:0]        signed_quo;
    logic               out_load;

    lhpb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_mag),
        .divisor  (look_cnt),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        clearing   = state_reg == ST_CLEAR;
        pop        = (state_reg == ST_IDLE) && !empty;
        rd_addr    = head.hit ? head.bin[BIN_W-1:0] : '0;
        look_cnt   = op_reg.hit ? cnt_rd_reg : 16'd0;
        div_mag    = sum_rd_reg[31] ? (32'd0 - sum_rd_reg) : sum_rd_reg;
        div_start  = (state_reg == ST_LOOK) && op_reg.is_read && (look_cnt != 16'd0);
        signed_quo = neg_reg ? (32'd0 - div_quo) : div_quo;
        out_load   = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);
        out_valid  = out_valid_reg;
        out_data   = out_data_reg;

        mem_we  = 1'b0;
        wr_addr = addr_reg;
        wr_sum  = '0;
        wr_cnt  = '0;
        if (state_reg == ST_CLEAR)
        begin
            mem_we  = 1'b1;
            wr_addr = clr_cnt_reg;
        end
        else if (state_reg == ST_LOOK)
        begin
            if (op_reg.is_read)
            begin
                mem_we = op_reg.hit;
            end
            else if (cnt_rd_reg != lhpb_pkg::COUNT_MAX)
            begin
                mem_we = 1'b1;
                wr_sum = sum_rd_reg + 32'($signed(op_reg.z_mm));
                wr_cnt = cnt_rd_reg + 16'd1;
            end
        end

        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == BIN_W'(BIN_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!empty)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (!op_reg.is_read)
                begin
                    state_next = ST_IDLE;
                end
                else if (div_start)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + BIN_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sum_mem_reg[wr_addr] <= wr_sum;
            cnt_mem_reg[wr_addr] <= wr_cnt;
        end
        sum_rd_reg <= sum_mem_reg[rd_addr];
        cnt_rd_reg <= cnt_mem_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg   <= head;
            addr_reg <= rd_addr;
        end
        if (state_reg == ST_LOOK)
        begin
            neg_reg                <= sum_rd_reg[31];
            res_reg.bin_index      <= op_reg.bin[6:0];
            res_reg.point_count    <= look_cnt;
            res_reg.mean_height_mm <= '0;
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            res_reg.mean_height_mm <= signed_quo[11:0];
        end
        if (out_load)
        begin
            out_data_reg <= res_reg;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lane_height_profile_binner.sv
// A read item passes the queue, the bin lookup and, when the bin holds points,
// the bit-serial divider before its result is registered; an empty bin skips
// the divider. The front takes one item a cycle, unless held by a full queue
// or the clearing sweep, into a four entry queue; the back takes one queued
// operation at a time. Reset: control and configuration registers return to
// their defaults and the bin memory is swept to zero, with in_stall held high.
// ----------------------------------------------------------------------------
// lane_height_profile_binner
// Binned average ground height profile along one wheel track from lidar
// points, with a read-and-clear request per bin.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lane_height_profile_binner #(
    parameter int BIN_COUNT = lhpb_pkg::DEF_BIN_COUNT,
    parameter int BIN_MM    = lhpb_pkg::DEF_BIN_MM
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire lhpb_pkg::in_item_t                 in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output lhpb_pkg::out_item_t                     out_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [lhpb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [lhpb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    lhpb_pkg::cfg_t cfg_reg;
    lhpb_pkg::op_t  push_op;
    lhpb_pkg::op_t  head;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;
    logic           clearing;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lane_center_mm     <= lhpb_pkg::RST_LANE_CENTER;
            cfg_reg.lane_half_width_mm <= lhpb_pkg::RST_HALF_WIDTH;
            cfg_reg.preview_limit_mm   <= lhpb_pkg::RST_PREVIEW;
            cfg_reg.height_limit_mm    <= lhpb_pkg::RST_HEIGHT_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lhpb_pkg::REG_LANE_CENTER:  cfg_reg.lane_center_mm     <= cfg_data[11:0];
                lhpb_pkg::REG_HALF_WIDTH:   cfg_reg.lane_half_width_mm <= cfg_data[9:0];
                lhpb_pkg::REG_PREVIEW:      cfg_reg.preview_limit_mm   <= cfg_data[14:0];
                lhpb_pkg::REG_HEIGHT_LIMIT: cfg_reg.height_limit_mm    <= cfg_data[10:0];
                default:
                begin
                end
            endcase
        end
    end

    lhpb_front #(
        .BIN_COUNT (BIN_COUNT),
        .BIN_MM    (BIN_MM)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .clearing   (clearing),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .push       (push),
        .push_op    (push_op),
        .queue_full (queue_full)
    );

    lhpb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    lhpb_back #(
        .BIN_COUNT (BIN_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clearing  (clearing),
        .head      (head),
        .empty     (queue_empty),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// File: hw/rtl/lhpb_checker.sv
// ----------------------------------------------------------------------------
// lhpb_checker
// Port level checks on the height profile binner, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lane_height_profile_binner_assert.svh"

module lhpb_checker #(
    parameter int BIN_COUNT = lhpb_pkg::DEF_BIN_COUNT
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire lhpb_pkg::out_item_t out_data
);

    `LHPB_ASSERT_NXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(out_data), "stalled result changed")

    `LHPB_ASSERT_IMP(a_empty_mean, out_valid && (out_data.point_count == 16'd0),
        out_data.mean_height_mm == 12'sd0, "empty bin gave a non-zero mean")

    `LHPB_ASSERT_IMP(a_far_bin, out_valid && (32'(out_data.bin_index) >= BIN_COUNT),
        (out_data.point_count == 16'd0) && (out_data.mean_height_mm == 12'sd0),
        "read beyond the last bin gave data")

    `LHPB_ASSERT_IMP(a_clear_stall, $rose(rst_n), in_stall,
        "item taken during the clearing sweep")

endmodule

bind lane_height_profile_binner lhpb_checker #(
    .BIN_COUNT (BIN_COUNT)
) u_lhpb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire
